### design/bthome_pkg.sv
// Package for the BTHome object stream parser: byte roles, status codes and
// the fixed value length table for known object types.
// Depends on nothing; used by bthome_object_stream_parser.
`timescale 1ns / 1ps

package bthome_pkg;

	localparam logic [7:0] TEXT_TYPE = 8'h53;

	localparam logic [1:0] ROLE_TYPE    = 2'd0;
	localparam logic [1:0] ROLE_TLEN    = 2'd1;
	localparam logic [1:0] ROLE_VALUE   = 2'd2;
	localparam logic [1:0] ROLE_IGNORED = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_UNKNOWN = 2'd1;
	localparam logic [1:0] STAT_TRUNC   = 2'd2;
	localparam logic [1:0] STAT_ZEROLEN = 2'd3;

	// Value length of a fixed-size object type; zero marks an unknown type.
	function automatic logic [2:0] fixed_len(input logic [7:0] t);
		logic [2:0] len;
		len = 3'd0;
		case (t) inside
			8'h00, 8'h01, 8'h09, 8'h0F, 8'h10, 8'h11, [8'h15:8'h2F],
			8'h46, 8'h57, 8'h58, 8'h59, 8'h60:
				len = 3'd1;
			8'h02, 8'h03, 8'h06, 8'h07, 8'h08, 8'h0C, 8'h0D, 8'h0E,
			8'h12, 8'h13, 8'h14, 8'h3D, 8'h3F, 8'h40, 8'h41, 8'h43,
			8'h44, 8'h45, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h51, 8'h52,
			8'h56, 8'h5A, 8'h5D, 8'h5E, 8'h5F, 8'h61, 8'hF0:
				len = 3'd2;
			8'h04, 8'h05, 8'h0A, 8'h0B, 8'h42, 8'h4B, 8'hF2:
				len = 3'd3;
			8'h3E, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h55, 8'h5B,
			8'h5C, 8'h62, 8'h63, 8'hF1:
				len = 3'd4;
			default:
				len = 3'd0;
		endcase
		return len;
	endfunction

endpackage

### design/bthome_object_stream_parser.sv
// BTHome object stream parser: splits a byte stream payload into
// type-length-value objects and tags every byte. Depends on bthome_pkg.
`timescale 1ns / 1ps

//  channel   direction  tdata                               tuser       tlast
//  s_axis    in         [7:0] payload_byte                  -           last_byte
//  m_axis    out        [7:0] object_type, [15:8] value_data,
//                       [23:16] value_index, [24] complete,
//                       [26:25] parse_status, [31:27] zero  [1:0] role  packet_end
//
// One byte per cycle while m_axis does not stall: each byte is handled by one table lookup
// and a counter update between the input handshake and the result register, so an item
// may be accepted every cycle and its result shows in the cycle after the handshake.
// A new item is taken whenever the result register is empty or being drained
// in the same cycle; a stall on m_axis holds the result and s_axis_tready.
// Reset (arst_n low) returns the parser to expect a type byte with no error.
// State also returns to reset values after every item that carries tlast.

module bthome_object_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] object_type, [15:8] value_data,
	                                    // [23:16] value_index, [24] object_complete,
	                                    // [26:25] parse_status, [31:27] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] byte_role
	output logic        m_axis_tlast    // packet_end
);

	typedef enum logic [1:0] {
		PH_TYPE,
		PH_TLEN,
		PH_VALUE,
		PH_STOP
	} phase_t;

	// Parser state, advanced on each accepted item.
	phase_t      phase_q;
	logic [7:0]  held_type_q;
	logic [7:0]  bytes_left_q;
	logic [7:0]  next_index_q;
	logic [1:0]  error_q;

	// Result register.
	logic        out_valid_q;
	logic [1:0]  role_q;
	logic [7:0]  type_q;
	logic [7:0]  data_q;
	logic [7:0]  index_q;
	logic        complete_q;
	logic        end_q;
	logic [1:0]  status_q;

	// Next-state and result values for the byte at the input.
	phase_t      phase_d;
	logic [7:0]  held_type_d;
	logic [7:0]  bytes_left_d;
	logic [7:0]  next_index_d;
	logic [1:0]  error_d;
	logic [1:0]  role_d;
	logic [7:0]  index_d;
	logic        complete_d;
	logic [2:0]  len;
	logic [7:0]  left_dec;
	logic        accept;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign len           = bthome_pkg::fixed_len(s_axis_tdata);
	assign left_dec      = bytes_left_q - 8'd1;

	always_comb begin
		phase_d      = phase_q;
		held_type_d  = held_type_q;
		bytes_left_d = bytes_left_q;
		next_index_d = next_index_q;
		error_d      = error_q;
		role_d       = bthome_pkg::ROLE_IGNORED;
		index_d      = 8'd0;
		complete_d   = 1'b0;
		unique case (phase_q)
			PH_TYPE: begin
				role_d      = bthome_pkg::ROLE_TYPE;
				held_type_d = s_axis_tdata;
				if (s_axis_tdata == bthome_pkg::TEXT_TYPE) begin
					phase_d = PH_TLEN;
					if (s_axis_tlast) begin
						error_d = bthome_pkg::STAT_TRUNC;
					end
				end else if (len == 3'd0) begin
					// Unknown type: stop and ignore the rest of the payload.
					error_d = bthome_pkg::STAT_UNKNOWN;
					phase_d = PH_STOP;
				end else begin
					bytes_left_d = {5'd0, len};
					next_index_d = 8'd0;
					phase_d      = PH_VALUE;
					if (s_axis_tlast) begin
						error_d = bthome_pkg::STAT_TRUNC;
					end
				end
			end
			PH_TLEN: begin
				role_d = bthome_pkg::ROLE_TLEN;
				if (s_axis_tdata == 8'd0) begin
					error_d = bthome_pkg::STAT_ZEROLEN;
					phase_d = PH_STOP;
				end else begin
					bytes_left_d = s_axis_tdata;
					next_index_d = 8'd0;
					phase_d      = PH_VALUE;
					if (s_axis_tlast) begin
						error_d = bthome_pkg::STAT_TRUNC;
					end
				end
			end
			PH_VALUE: begin
				role_d       = bthome_pkg::ROLE_VALUE;
				index_d      = next_index_q;
				next_index_d = next_index_q + 8'd1;
				bytes_left_d = left_dec;
				if (left_dec == 8'd0) begin
					complete_d = 1'b1;
					phase_d    = PH_TYPE;
				end else if (s_axis_tlast) begin
					// Payload ends inside the value.
					error_d = bthome_pkg::STAT_TRUNC;
				end
			end
			PH_STOP: begin
				role_d = bthome_pkg::ROLE_IGNORED;
			end
			default: begin
				role_d = bthome_pkg::ROLE_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TYPE;
			held_type_q  <= 8'd0;
			bytes_left_q <= 8'd0;
			next_index_q <= 8'd0;
			error_q      <= bthome_pkg::STAT_OK;
			out_valid_q  <= 1'b0;
			role_q       <= bthome_pkg::ROLE_TYPE;
			type_q       <= 8'd0;
			data_q       <= 8'd0;
			index_q      <= 8'd0;
			complete_q   <= 1'b0;
			end_q        <= 1'b0;
			status_q     <= bthome_pkg::STAT_OK;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				// Load the result only when a new item is taken.
				role_q      <= role_d;
				type_q      <= held_type_d;
				data_q      <= s_axis_tdata;
				index_q     <= index_d;
				complete_q  <= complete_d;
				end_q       <= s_axis_tlast;
				status_q    <= error_d;
				if (s_axis_tlast) begin
					// Packet end: return all parser state to reset values.
					phase_q      <= PH_TYPE;
					held_type_q  <= 8'd0;
					bytes_left_q <= 8'd0;
					next_index_q <= 8'd0;
					error_q      <= bthome_pkg::STAT_OK;
				end else begin
					phase_q      <= phase_d;
					held_type_q  <= held_type_d;
					bytes_left_q <= bytes_left_d;
					next_index_q <= next_index_d;
					error_q      <= error_d;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = role_q;
	assign m_axis_tlast  = end_q;
	assign m_axis_tdata  = {5'd0, status_q, complete_q, index_q, data_q, type_q};

	// A completed object is only ever flagged on a value byte.
	a_complete_on_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && complete_q) |-> (role_q == bthome_pkg::ROLE_VALUE))
		else $error("complete flag on a non-value byte");

	// Ignored bytes follow only an unknown type or a zero text length.
	a_ignored_has_error: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && role_q == bthome_pkg::ROLE_IGNORED) |->
		(status_q == bthome_pkg::STAT_UNKNOWN || status_q == bthome_pkg::STAT_ZEROLEN))
		else $error("ignored byte without a stop status");

	// Inside a value there is always at least one byte still to come.
	a_value_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_VALUE) |-> (bytes_left_q != 8'd0))
		else $error("value phase with no bytes left");

	// The last byte of a packet leaves the parser clean for the next one.
	a_packet_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tlast) |=>
		(phase_q == PH_TYPE && error_q == bthome_pkg::STAT_OK))
		else $error("state not cleared after packet end");

endmodule

### sim/tb.sv
// Self-checking bench for bthome_object_stream_parser: drives payloads over
// s_axis and checks every tagged byte on m_axis against its own parser model.
// Depends on bthome_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb;

	typedef enum logic [1:0] {
		EXPECT_TYPE,
		EXPECT_TLEN,
		IN_VALUE,
		STOPPED
	} parse_phase_t;

	typedef struct packed {
		logic [1:0] role;
		logic [7:0] type_code;
		logic [7:0] data;
		logic [7:0] index;
		logic       complete;
		logic       pkt_end;
		logic [1:0] status;
	} tagged_byte_t;

	// Tracks the parser state for every accepted payload byte and holds the
	// tagged bytes still owed on the output, oldest first.
	class tag_scoreboard_t;
		parse_phase_t phase;
		logic [7:0]   cur_type;
		logic [7:0]   left;
		logic [7:0]   idx;
		logic [1:0]   status;
		tagged_byte_t pending_tags[$];
		int unsigned  mismatches = 0;
		int unsigned  checked = 0;
		int unsigned  accepted = 0;
		int unsigned  parsed = 0;
		int unsigned  packets = 0;
		int unsigned  objects = 0;
		int unsigned  top_index = 0;
		int unsigned  status_seen[4] = '{0, 0, 0, 0};

		function new();
			clear_state();
		endfunction

		// Value bytes that follow a fixed-size type; zero for an unknown type.
		static function int unsigned value_len(logic [7:0] t);
			if (t >= 8'h15 && t <= 8'h2F)
				return 1;
			case (t)
			8'h00, 8'h01, 8'h09, 8'h0F, 8'h10, 8'h11, 8'h46, 8'h57, 8'h58,
			8'h59, 8'h60:
				return 1;
			8'h02, 8'h03, 8'h06, 8'h07, 8'h08, 8'h0C, 8'h0D, 8'h0E, 8'h12,
			8'h13, 8'h14, 8'h3D, 8'h3F, 8'h40, 8'h41, 8'h43, 8'h44, 8'h45,
			8'h47, 8'h48, 8'h49, 8'h4A, 8'h51, 8'h52, 8'h56, 8'h5A, 8'h5D,
			8'h5E, 8'h5F, 8'h61, 8'hF0:
				return 2;
			8'h04, 8'h05, 8'h0A, 8'h0B, 8'h42, 8'h4B, 8'hF2:
				return 3;
			8'h3E, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h55, 8'h5B, 8'h5C,
			8'h62, 8'h63, 8'hF1:
				return 4;
			default:
				return 0;
			endcase
		endfunction

		function void clear_state();
			phase    = EXPECT_TYPE;
			cur_type = 8'h00;
			left     = 8'h00;
			idx      = 8'h00;
			status   = bthome_pkg::STAT_OK;
		endfunction

		function void note_payload_byte(logic [7:0] b, logic last);
			tagged_byte_t t;
			int unsigned  len;
			t = '{role: bthome_pkg::ROLE_IGNORED, type_code: 8'h00, data: b,
				index: 8'h00, complete: 1'b0, pkt_end: last,
				status: bthome_pkg::STAT_OK};
			accepted++;
			case (phase)
			EXPECT_TYPE: begin
				t.role   = bthome_pkg::ROLE_TYPE;
				cur_type = b;
				if (b == bthome_pkg::TEXT_TYPE) begin
					phase = EXPECT_TLEN;
					if (last)
						status = bthome_pkg::STAT_TRUNC;
				end else begin
					len = value_len(b);
					if (len == 0) begin
						status = bthome_pkg::STAT_UNKNOWN;
						phase  = STOPPED;
					end else begin
						left  = len[7:0];
						idx   = 8'h00;
						phase = IN_VALUE;
						if (last)
							status = bthome_pkg::STAT_TRUNC;
					end
				end
			end
			EXPECT_TLEN: begin
				t.role = bthome_pkg::ROLE_TLEN;
				if (b == 8'h00) begin
					status = bthome_pkg::STAT_ZEROLEN;
					phase  = STOPPED;
				end else begin
					left  = b;
					idx   = 8'h00;
					phase = IN_VALUE;
					if (last)
						status = bthome_pkg::STAT_TRUNC;
				end
			end
			IN_VALUE: begin
				t.role  = bthome_pkg::ROLE_VALUE;
				t.index = idx;
				if (idx > top_index)
					top_index = 32'(idx);
				idx  = idx + 8'd1;
				left = left - 8'd1;
				if (left == 8'h00) begin
					t.complete = 1'b1;
					phase      = EXPECT_TYPE;
					objects++;
				end else if (last) begin
					status = bthome_pkg::STAT_TRUNC;
				end
			end
			default: begin
				t.role = bthome_pkg::ROLE_IGNORED;
			end
			endcase
			if (t.role != bthome_pkg::ROLE_IGNORED)
				parsed++;
			t.type_code = cur_type;
			t.status    = status;
			pending_tags.push_back(t);
			if (last) begin
				packets++;
				status_seen[status]++;
				clear_state();
			end
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			$display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
				$realtime, checked, what, got, want);
		endtask

		task check_tagged_byte(logic [31:0] d, logic [1:0] u, logic l);
			tagged_byte_t want;
			checked++;
			if (pending_tags.size() == 0) begin
				report("arrived with nothing expected", d, 32'h0);
				return;
			end
			want = pending_tags.pop_front();
			if (u !== want.role)
				report("byte_role", 32'(u), 32'(want.role));
			if (d[7:0] !== want.type_code)
				report("object_type", 32'(d[7:0]), 32'(want.type_code));
			if (d[15:8] !== want.data)
				report("value_data", 32'(d[15:8]), 32'(want.data));
			if (d[23:16] !== want.index)
				report("value_index", 32'(d[23:16]), 32'(want.index));
			if (d[24] !== want.complete)
				report("object_complete", 32'(d[24]), 32'(want.complete));
			if (d[26:25] !== want.status)
				report("parse_status", 32'(d[26:25]), 32'(want.status));
			if (d[31:27] !== 5'd0)
				report("tdata padding", 32'(d[31:27]), 32'h0);
			if (l !== want.pkt_end)
				report("packet_end", 32'(l), 32'(want.pkt_end));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	tag_scoreboard_t sb = new();

	// Stimulus state shared with the receiver process.
	bit          quiet = 1'b0;
	int unsigned hold_requests = 0;
	int unsigned holds_served = 0;
	int unsigned rx_hold = 0;
	int unsigned rx_wait = 0;

	logic [7:0]  payload[$];
	logic [7:0]  known_types[$];

	bthome_object_stream_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Receiver: random stalls, plus one long hold-off on request so that the
	// parser fills up and pushes back on its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (holds_served != hold_requests) begin
			holds_served  = hold_requests;
			rx_hold       = 400;
			m_axis_tready <= 1'b0;
		end else if (rx_hold != 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else if (rx_wait != 0) begin
			rx_wait--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 3) == 0)
				rx_wait = idle_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_payload_byte(s_axis_tdata, s_axis_tlast);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_tagged_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// Offer one item after an optional gap; return at the accepting edge with
	// tvalid still high so back-to-back items need no extra assignment.
	task automatic send_item(input logic [7:0] b, input logic last);
		int unsigned gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 2) == 0)
			gap = idle_len();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic send_payload();
		foreach (payload[i])
			send_item(payload[i], i == payload.size() - 1);
	endtask

	// Hold the sender until every tagged byte owed has come back.
	task automatic wait_drained();
		while (sb.pending_tags.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_text(input int unsigned len);
		payload.push_back(bthome_pkg::TEXT_TYPE);
		payload.push_back(len[7:0]);
		repeat (len) payload.push_back(8'($urandom_range(0, 255)));
	endtask

	// Append one well-formed object with random content.
	task automatic add_object();
		logic [7:0]  t;
		int unsigned len;
		if ($urandom_range(0, 3) == 0) begin
			if ($urandom_range(0, 24) == 0)
				len = $urandom_range(129, 255);
			else
				len = $urandom_range(1, 10);
			add_text(len);
		end else begin
			t = known_types[$urandom_range(0, known_types.size() - 1)];
			payload.push_back(t);
			repeat (tag_scoreboard_t::value_len(t))
				payload.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Random payload: mostly well-formed, some cut short, some broken by an
	// unknown type or an empty text, some plain noise.
	task automatic build_random_payload();
		int unsigned kind;
		int unsigned n_obj;
		int unsigned cut;
		logic [7:0]  bad;
		payload.delete();
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			repeat ($urandom_range(1, 8)) payload.push_back(8'($urandom_range(0, 255)));
			return;
		end
		n_obj = $urandom_range(1, 5);
		repeat (n_obj) add_object();
		if (kind == 7 && payload.size() > 1) begin
			cut = $urandom_range(0, payload.size() - 2);
			payload = payload[0:cut];
		end else if (kind == 8) begin
			if ($urandom_range(0, 1) == 0) begin
				do
					bad = 8'($urandom_range(0, 255));
				while (tag_scoreboard_t::value_len(bad) != 0 ||
					bad == bthome_pkg::TEXT_TYPE);
				payload.push_back(bad);
			end else begin
				payload.push_back(bthome_pkg::TEXT_TYPE);
				payload.push_back(8'h00);
			end
			// Anything after the stop must come out ignored.
			repeat ($urandom_range(0, 4)) payload.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1) == 0)
				add_object();
		end
	endtask

	initial begin
		int unsigned pkt;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'h00;
		s_axis_tlast  <= 1'b0;
		arst_n        <= 1'b0;
		for (int t = 0; t < 256; t++)
			if (tag_scoreboard_t::value_len(t[7:0]) != 0)
				known_types.push_back(t[7:0]);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: objects of value length one, four and three, a text object and a clean end.
		payload = '{8'h00, 8'hFF, 8'h3E, 8'h01, 8'h02, 8'h04, 8'h80,
			bthome_pkg::TEXT_TYPE, 8'h02, 8'h7F, 8'hFE, 8'hF2, 8'h08, 8'h10, 8'h20};
		send_payload();
		// Empty text stops parsing; the byte after it is ignored.
		payload = '{bthome_pkg::TEXT_TYPE, 8'h00, 8'hAA};
		send_payload();
		// Unknown type, then an ignored byte.
		payload = '{8'hFF, 8'h55};
		send_payload();
		// Payload ends inside a value.
		payload = '{8'h61, 8'h40};
		send_payload();
		// Payload ends on a text type byte, then on a nonzero text length.
		payload = '{bthome_pkg::TEXT_TYPE};
		send_payload();
		payload = '{bthome_pkg::TEXT_TYPE, 8'h05};
		send_payload();
		// Unknown type and empty text on the final byte report their own code.
		payload = '{8'hFF};
		send_payload();
		payload = '{bthome_pkg::TEXT_TYPE, 8'h00};
		send_payload();
		// Known fixed type as the only byte.
		payload = '{8'h02};
		send_payload();
		s_axis_tvalid <= 1'b0;
		wait_drained();

		pkt = 0;
		while (sb.parsed < 1030) begin
			if (pkt == 5)
				hold_requests++;
			quiet = (pkt >= 20 && pkt < 40);
			if (pkt == 10) begin
				// Longest text value: every bit of the index gets exercised.
				payload.delete();
				add_object();
				add_text(255);
				add_object();
			end else begin
				build_random_payload();
			end
			send_payload();
			if (pkt == 60) begin
				s_axis_tvalid <= 1'b0;
				wait_drained();
				@(posedge clk);
			end
			pkt++;
		end
		s_axis_tvalid <= 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Covered %0d payload bytes (%0d parsed) in %0d packets, %0d whole objects,",
			sb.accepted, sb.parsed, sb.packets, sb.objects);
		$display("value index up to %0d; endings ok %0d, unknown %0d, truncated %0d, %s %0d.",
			sb.top_index, sb.status_seen[bthome_pkg::STAT_OK],
			sb.status_seen[bthome_pkg::STAT_UNKNOWN],
			sb.status_seen[bthome_pkg::STAT_TRUNC], "empty text",
			sb.status_seen[bthome_pkg::STAT_ZEROLEN]);
		if (sb.mismatches == 0 && sb.pending_tags.size() == 0) begin
			$display("[bthome_object_stream_parser] OK");
		end else begin
			$display("[bthome_object_stream_parser] ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("Timed out with %0d tagged bytes still owed", sb.pending_tags.size());
		$display("[bthome_object_stream_parser] ERROR");
		$finish;
	end

endmodule

### bthome_object_stream_parser.f
design/bthome_pkg.sv
design/bthome_object_stream_parser.sv
sim/tb.sv
